/* hdl/assert_macros.svh */
// ============================================================================
// assert_macros.svh
// Assertion macros used by the checker module of this project.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* hdl/jvbs_pkg.sv */
// ============================================================================
// jvbs_pkg
// Types, constants and byte classification helpers for the JSON value
// boundary scanner.
// ============================================================================
package jvbs_pkg;

    localparam int LEN_BITS   = 16;
    localparam int DEPTH_BITS = 8;
    localparam int OUT_BITS   = 16;

    localparam logic [LEN_BITS-1:0]   LEN_MAX   = '1;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    typedef enum logic [2:0] {
        PH_LEAD = 3'd0,
        PH_NEST = 3'd1,
        PH_STR  = 3'd2,
        PH_BARE = 3'd3,
        PH_TAIL = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_COMPLETE   = 2'd0,
        ST_INCOMPLETE = 2'd1,
        ST_TRAILING   = 2'd2,
        ST_LIMIT      = 2'd3
    } t_status;

    typedef struct packed {
        t_phase                phase;
        logic [DEPTH_BITS-1:0] nest_depth;
        logic                  inside_string;
        logic                  after_backslash;
        logic [LEN_BITS-1:0]   byte_position;
        logic [LEN_BITS-1:0]   end_offset;
        logic                  trailing_seen;
        logic                  limit_hit;
    } t_scan_state;

    typedef struct packed {
        t_status             status;
        logic [OUT_BITS-1:0] value_end;
        logic [OUT_BITS-1:0] body_length;
    } t_result;

    localparam t_scan_state SCAN_RESET = '{
        phase:           PH_LEAD,
        nest_depth:      '0,
        inside_string:   1'b0,
        after_backslash: 1'b0,
        byte_position:   '0,
        end_offset:      '0,
        trailing_seen:   1'b0,
        limit_hit:       1'b0
    };

    function automatic logic is_white(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

    function automatic logic is_open(input logic [7:0] b);
        return (b == CH_LBRACE) || (b == CH_LBRACKET);
    endfunction

    function automatic logic is_close(input logic [7:0] b);
        return (b == CH_RBRACE) || (b == CH_RBRACKET);
    endfunction

    // Low OUT_BITS bits of a count, zero-extended when the count is narrower.
    function automatic logic [OUT_BITS-1:0] fit_out(input logic [LEN_BITS-1:0] v);
        logic [LEN_BITS+OUT_BITS-1:0] w;
        w = (LEN_BITS + OUT_BITS)'(v);
        return w[OUT_BITS-1:0];
    endfunction

endpackage

/* hdl/json_value_boundary_scanner_unit.sv */
// ============================================================================
// json_value_boundary_scanner_unit
// Finds where the first JSON value of a message body ends. The body arrives
// as one transaction per byte, and an item with i_last_byte high closes it.
// Leading whitespace is skipped, objects and arrays are followed with one
// shared bracket depth that ignores brackets inside strings, quoted strings
// end at the unescaped closing quote and bare scalars end at whitespace or
// at the end of the body. Only the last item of a body produces an output
// transaction, carrying a status (complete, incomplete or empty, trailing
// bytes, limit exceeded), the offset just past the value and the body
// length. The unit accepts one transaction per clock cycle while o_stall is
// low. An item is captured in an input register, the scan state is updated
// by combinational logic after it, and the result lands in an output
// register. The rate is set by that update of the scan state, which every
// byte depends on. The input side stalls only when a last item is waiting,
// the output register is still full and the output side stalls.
// ============================================================================
module json_value_boundary_scanner_unit import jvbs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last_byte,
    // Output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_value_end,
    output logic [15:0] o_body_length
);

    // Input register.
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_has;
    logic        r_in_last;

    // Scan state carried from byte to byte within one body.
    t_scan_state r_state;
    t_scan_state n_state;

    // Output register.
    logic        r_out_vld;
    t_result     r_out;
    t_result     n_out;

    logic        w_go;

    // The held item moves on unless it carries a result and the output
    // register cannot take it in this cycle.
    assign w_go    = r_in_vld && !(r_in_last && r_out_vld && i_stall);
    assign o_stall = r_in_vld && !w_go;

    jvbs_step u_step (
        .i_state      (r_state),
        .i_data_byte  (r_in_byte),
        .i_has_byte   (r_in_has),
        .i_last_byte  (r_in_last),
        .o_next_state (n_state),
        .o_result     (n_out)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= SCAN_RESET;
        end else begin
            if (!o_stall) begin
                r_in_vld <= i_valid;
            end
            if (w_go) begin
                r_state <= n_state;
            end
            if (w_go && r_in_last) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_data_byte;
            r_in_has  <= i_has_byte;
            r_in_last <= i_last_byte;
        end
        if (w_go && r_in_last) begin
            r_out <= n_out;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_status      = r_out.status;
    assign o_value_end   = r_out.value_end;
    assign o_body_length = r_out.body_length;

endmodule

/* hdl/jvbs_step.sv */
// ============================================================================
// jvbs_step
// Next-state and result logic for one body item of the scanner.
// ============================================================================
module jvbs_step import jvbs_pkg::*; (
    input  t_scan_state i_state,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last_byte,
    output t_scan_state o_next_state,
    output t_result     o_result
);

    logic [LEN_BITS-1:0] pos_inc;
    logic                pos_full;
    t_scan_state         scanned;
    t_scan_state         updated;

    assign pos_inc  = i_state.byte_position + 1'b1;
    assign pos_full = (i_state.byte_position == LEN_MAX);

    // Effect of the byte on the value tracker, assuming it is counted.
    always_comb begin
        scanned = i_state;
        scanned.byte_position = pos_inc;
        unique case (i_state.phase)
            PH_LEAD: begin
                if (!is_white(i_data_byte)) begin
                    if (is_open(i_data_byte)) begin
                        scanned.nest_depth = DEPTH_BITS'(1);
                        scanned.phase      = PH_NEST;
                    end else if (i_data_byte == CH_QUOTE) begin
                        scanned.after_backslash = 1'b0;
                        scanned.phase           = PH_STR;
                    end else begin
                        scanned.phase = PH_BARE;
                    end
                end
            end
            PH_NEST: begin
                if (i_state.inside_string) begin
                    if (i_state.after_backslash) begin
                        scanned.after_backslash = 1'b0;
                    end else if (i_data_byte == CH_BACKSLASH) begin
                        scanned.after_backslash = 1'b1;
                    end else if (i_data_byte == CH_QUOTE) begin
                        scanned.inside_string = 1'b0;
                    end
                end else if (i_data_byte == CH_QUOTE) begin
                    scanned.inside_string = 1'b1;
                end else if (is_open(i_data_byte)) begin
                    if (i_state.nest_depth == DEPTH_MAX) begin
                        scanned.limit_hit = 1'b1;
                    end else begin
                        scanned.nest_depth = i_state.nest_depth + 1'b1;
                    end
                end else if (is_close(i_data_byte)) begin
                    scanned.nest_depth = i_state.nest_depth - 1'b1;
                    if (i_state.nest_depth == DEPTH_BITS'(1)) begin
                        scanned.end_offset = pos_inc;
                        scanned.phase      = PH_TAIL;
                    end
                end
            end
            PH_STR: begin
                if (i_state.after_backslash) begin
                    scanned.after_backslash = 1'b0;
                end else if (i_data_byte == CH_BACKSLASH) begin
                    scanned.after_backslash = 1'b1;
                end else if (i_data_byte == CH_QUOTE) begin
                    scanned.end_offset = pos_inc;
                    scanned.phase      = PH_TAIL;
                end
            end
            PH_BARE: begin
                if (is_white(i_data_byte)) begin
                    scanned.end_offset = i_state.byte_position;
                    scanned.phase      = PH_TAIL;
                end
            end
            default: begin
                if (!is_white(i_data_byte)) begin
                    scanned.trailing_seen = 1'b1;
                end
            end
        endcase
    end

    // Once a limit is flagged, bytes are only counted up to the count ceiling.
    always_comb begin
        updated = i_state;
        if (i_has_byte) begin
            if (!i_state.limit_hit) begin
                if (pos_full) begin
                    updated.limit_hit = 1'b1;
                end else begin
                    updated = scanned;
                end
            end else if (!pos_full) begin
                updated.byte_position = pos_inc;
            end
        end
    end

    always_comb begin
        o_result.value_end   = '0;
        o_result.body_length = fit_out(updated.byte_position);
        if (updated.limit_hit) begin
            o_result.status = ST_LIMIT;
        end else if (updated.phase == PH_BARE) begin
            o_result.status    = ST_COMPLETE;
            o_result.value_end = fit_out(updated.byte_position);
        end else if (updated.phase == PH_TAIL) begin
            o_result.status    = updated.trailing_seen ? ST_TRAILING : ST_COMPLETE;
            o_result.value_end = fit_out(updated.end_offset);
        end else begin
            o_result.status = ST_INCOMPLETE;
        end
    end

    assign o_next_state = i_last_byte ? SCAN_RESET : updated;

endmodule

/* hdl/jvbs_checker.sv */
// ============================================================================
// jvbs_checker
// Port-level checks for the JSON value boundary scanner.
// ============================================================================
`include "assert_macros.svh"

module jvbs_checker import jvbs_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [15:0] o_value_end,
    input logic [15:0] o_body_length
);

    // A stalled result keeps its contents.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_value_end) && $stable(o_body_length))

    // No value end is reported for an incomplete body or a limit overflow.
    `ASSERT_IMPLIES(a_no_end_without_value, i_clk, i_rst_n, o_valid && (o_status == ST_INCOMPLETE || o_status == ST_LIMIT), o_value_end == 16'd0)

    // A found value always spans at least one byte.
    `ASSERT_IMPLIES(a_value_nonempty, i_clk, i_rst_n, o_valid && (o_status == ST_COMPLETE || o_status == ST_TRAILING), o_value_end != 16'd0)

endmodule

bind json_value_boundary_scanner_unit jvbs_checker u_jvbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status      (o_status),
    .o_value_end   (o_value_end),
    .o_body_length (o_body_length)
);

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the JSON value boundary scanner. A short table of
// hand-picked bodies and one long body that overflows the depth counter
// come first. Randomly built bodies follow: mostly well-formed values
// with random content, plus truncated values, noise and trailing garbage.
// Every accepted item runs through a behavioral predictor, and each output
// transaction is compared field by field with the oldest pending report.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jvbs_pkg::*;

    // The run ends well within this limit, even with every item waiting out the
    // longest gap and every report the longest stall.
    localparam int CYCLE_LIMIT  = 100_000;
    localparam int RANDOM_ITEMS = 380;

    localparam t_result NO_WANT = '{ST_COMPLETE, 16'd0, 16'd0};

    // One row of the directed table. When typed is set, want holds the
    // report that the closing item must produce; otherwise the predictor
    // decides.
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
        logic       typed;
        t_result    want;
    } t_row;

    localparam int PLAN_LEN = 26;
    localparam t_row PLAN [PLAN_LEN] = '{
        // Empty body: the very first item closes it without a byte.
        '{8'h00,        1'b0, 1'b1, 1'b1, '{ST_INCOMPLETE, 16'd0, 16'd0}},
        // Item with no byte that is not last must be ignored.
        '{8'hFF,        1'b0, 1'b0, 1'b0, NO_WANT},
        // One-byte scalar that runs to the end of the body.
        '{"7",          1'b1, 1'b1, 1'b1, '{ST_COMPLETE, 16'd1, 16'd1}},
        // Whitespace only.
        '{CH_TAB,       1'b1, 1'b0, 1'b0, NO_WANT},
        '{CH_LF,        1'b1, 1'b0, 1'b0, NO_WANT},
        '{CH_CR,        1'b1, 1'b1, 1'b1, '{ST_INCOMPLETE, 16'd0, 16'd3}},
        // Object holding a string with an escaped quote and a closing brace,
        // then a nested array, then one trailing non-whitespace byte.
        '{CH_LBRACE,    1'b1, 1'b0, 1'b0, NO_WANT},
        '{CH_QUOTE,     1'b1, 1'b0, 1'b0, NO_WANT},
        '{CH_BACKSLASH, 1'b1, 1'b0, 1'b0, NO_WANT},
        '{CH_QUOTE,     1'b1, 1'b0, 1'b0, NO_WANT},
        '{CH_RBRACE,    1'b1, 1'b0, 1'b0, NO_WANT},
        '{CH_QUOTE,     1'b1, 1'b0, 1'b0, NO_WANT},
        '{CH_LBRACKET,  1'b1, 1'b0, 1'b0, NO_WANT},
        '{CH_RBRACKET,  1'b1, 1'b0, 1'b0, NO_WANT},
        '{CH_RBRACE,    1'b1, 1'b0, 1'b0, NO_WANT},
        '{"x",          1'b1, 1'b1, 1'b0, NO_WANT},
        // Quoted string with an escaped backslash, a space after it, and a
        // body that ends on an item without a byte.
        '{CH_QUOTE,     1'b1, 1'b0, 1'b0, NO_WANT},
        '{CH_BACKSLASH, 1'b1, 1'b0, 1'b0, NO_WANT},
        '{CH_BACKSLASH, 1'b1, 1'b0, 1'b0, NO_WANT},
        '{CH_QUOTE,     1'b1, 1'b0, 1'b0, NO_WANT},
        '{CH_SPACE,     1'b1, 1'b0, 1'b0, NO_WANT},
        '{8'h00,        1'b0, 1'b1, 1'b0, NO_WANT},
        // Scalar made of a zero byte, ended by whitespace, then an all-ones
        // trailing byte.
        '{8'h00,        1'b1, 1'b0, 1'b0, NO_WANT},
        '{CH_CR,        1'b1, 1'b0, 1'b0, NO_WANT},
        '{8'hFF,        1'b1, 1'b1, 1'b0, NO_WANT},
        // Array that never closes.
        '{CH_LBRACKET,  1'b1, 1'b1, 1'b1, '{ST_INCOMPLETE, 16'd0, 16'd1}}
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_has_byte  = 1'b0;
    logic        i_last_byte = 1'b0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [15:0] o_value_end;
    logic [15:0] o_body_length;

    // Predictor state for the body in flight, and the reports it has
    // promised but the unit has not yet delivered.
    t_scan_state scan_view = SCAN_RESET;
    t_result     expected_reports [$];
    logic [7:0]  body_bytes [$];

    int mismatches   = 0;
    int cycles       = 0;
    int random_items = 0;
    int stall_left   = 0;
    bit calm         = 1'b0;

    json_value_boundary_scanner_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_has_byte    (i_has_byte),
        .i_last_byte   (i_last_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_value_end   (o_value_end),
        .o_body_length (o_body_length)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit blank(input logic [7:0] b);
        return b inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
    endfunction

    // Advances the scan by one counted byte. The byte position has already
    // been bumped, so it is the offset just past this byte.
    task automatic scan_byte(input logic [7:0] b);
        case (scan_view.phase)
            PH_LEAD: begin
                if (!blank(b)) begin
                    if (b == CH_LBRACE || b == CH_LBRACKET) begin
                        scan_view.nest_depth = DEPTH_BITS'(1);
                        scan_view.phase      = PH_NEST;
                    end else if (b == CH_QUOTE) begin
                        scan_view.after_backslash = 1'b0;
                        scan_view.phase           = PH_STR;
                    end else begin
                        scan_view.phase = PH_BARE;
                    end
                end
            end
            PH_NEST: begin
                if (scan_view.inside_string) begin
                    if (scan_view.after_backslash)
                        scan_view.after_backslash = 1'b0;
                    else if (b == CH_BACKSLASH)
                        scan_view.after_backslash = 1'b1;
                    else if (b == CH_QUOTE)
                        scan_view.inside_string = 1'b0;
                end else if (b == CH_QUOTE) begin
                    scan_view.inside_string = 1'b1;
                end else if (b == CH_LBRACE || b == CH_LBRACKET) begin
                    if (scan_view.nest_depth >= DEPTH_MAX)
                        scan_view.limit_hit = 1'b1;
                    else
                        scan_view.nest_depth++;
                end else if (b == CH_RBRACE || b == CH_RBRACKET) begin
                    scan_view.nest_depth--;
                    if (scan_view.nest_depth == 0) begin
                        scan_view.end_offset = scan_view.byte_position;
                        scan_view.phase      = PH_TAIL;
                    end
                end
            end
            PH_STR: begin
                if (scan_view.after_backslash) begin
                    scan_view.after_backslash = 1'b0;
                end else if (b == CH_BACKSLASH) begin
                    scan_view.after_backslash = 1'b1;
                end else if (b == CH_QUOTE) begin
                    scan_view.end_offset = scan_view.byte_position;
                    scan_view.phase      = PH_TAIL;
                end
            end
            PH_BARE: begin
                // The whitespace byte itself is not part of the scalar.
                if (blank(b)) begin
                    scan_view.end_offset = scan_view.byte_position - 1'b1;
                    scan_view.phase      = PH_TAIL;
                end
            end
            default: begin
                if (!blank(b))
                    scan_view.trailing_seen = 1'b1;
            end
        endcase
    endtask

    // Works out what one accepted item does. A closing item yields the
    // report for the body and returns the scan to its idle state.
    task automatic predict_boundary(input logic [7:0] b, input logic h, input logic l,
                                    output bit produced, output t_result r);
        r        = NO_WANT;
        produced = 1'b0;
        if (h && !scan_view.limit_hit) begin
            // A byte that finds the counter already full is neither counted
            // nor scanned, and flags the body.
            if (scan_view.byte_position >= LEN_MAX) begin
                scan_view.limit_hit = 1'b1;
            end else begin
                scan_view.byte_position++;
                scan_byte(b);
            end
        end else if (h && scan_view.byte_position < LEN_MAX) begin
            // After a depth overflow bytes are still counted.
            scan_view.byte_position++;
        end
        if (l) begin
            produced      = 1'b1;
            r.body_length = scan_view.byte_position;
            if (scan_view.limit_hit) begin
                r.status = ST_LIMIT;
            end else if (scan_view.phase == PH_BARE) begin
                r.status    = ST_COMPLETE;
                r.value_end = scan_view.byte_position;
            end else if (scan_view.phase == PH_TAIL) begin
                r.status    = scan_view.trailing_seen ? ST_TRAILING : ST_COMPLETE;
                r.value_end = scan_view.end_offset;
            end else begin
                r.status = ST_INCOMPLETE;
            end
            scan_view = SCAN_RESET;
        end
    endtask

    // Offers one item, at times with a random idle burst in front of it, and holds
    // it until the unit takes it. The acceptance edge is where the item is
    // handed to the predictor.
    task automatic send_item(input logic [7:0] d, input logic h, input logic l,
                             input bit typed = 1'b0, input t_result want = NO_WANT);
        bit      produced;
        t_result r;
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= d;
        i_has_byte  <= h;
        i_last_byte <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_boundary(d, h, l, produced, r);
        if (produced)
            expected_reports.push_back(typed ? want : r);
    endtask

    function automatic logic [7:0] white_byte();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    // Any byte that neither ends a string nor escapes inside one.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_QUOTE || b == CH_BACKSLASH);
        return b;
    endfunction

    // Quoted string with escapes and stray brackets mixed in, so that the
    // string tracking inside containers gets exercised.
    task automatic add_string();
        int n;
        body_bytes.push_back(CH_QUOTE);
        n = $urandom_range(0, 6);
        repeat (n) begin
            case ($urandom_range(0, 4))
                0: begin
                    body_bytes.push_back(CH_BACKSLASH);
                    body_bytes.push_back($urandom_range(0, 1) ? CH_QUOTE
                                                              : 8'($urandom_range(0, 255)));
                end
                1: body_bytes.push_back($urandom_range(0, 1) ? CH_RBRACE : CH_LBRACKET);
                default: body_bytes.push_back(plain_byte());
            endcase
        end
        body_bytes.push_back(CH_QUOTE);
    endtask

    // Balanced object or array of random shape. Past max_len bytes it only
    // closes, so the body stays short.
    task automatic add_container(input int max_len);
        int depth;
        int pick;
        body_bytes.push_back($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACKET);
        depth = 1;
        while (depth > 0) begin
            pick = (body_bytes.size() > max_len) ? 3 : $urandom_range(0, 9);
            if (pick < 2 && depth < 5) begin
                body_bytes.push_back($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACKET);
                depth++;
            end else if (pick < 5) begin
                body_bytes.push_back($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACKET);
                depth--;
            end else if (pick < 7) begin
                add_string();
            end else if (pick < 8) begin
                body_bytes.push_back(8'($urandom_range(8'h30, 8'h39)));
            end else begin
                case ($urandom_range(0, 2))
                    0:       body_bytes.push_back(",");
                    1:       body_bytes.push_back(":");
                    default: body_bytes.push_back(white_byte());
                endcase
            end
        end
    endtask

    // Receiver side: random stall bursts, none once the run has gone calm.
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            stall_left <= 0;
            i_stall    <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 8);
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Every output transaction must match the oldest pending report.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report: status=%0d value_end=%0d body_length=%0d",
                             o_status, o_value_end, o_body_length);
            end else begin
                want = expected_reports.pop_front();
                if (o_status !== want.status || o_value_end !== want.value_end ||
                    o_body_length !== want.body_length) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"report mismatch: expected status=%0d value_end=%0d ",
                                  "body_length=%0d, got status=%0d value_end=%0d ",
                                  "body_length=%0d"},
                                 want.status, want.value_end, want.body_length,
                                 o_status, o_value_end, o_body_length);
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        bit         closing_item;
        int         keep;
        logic [7:0] b;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (PLAN[k])
            send_item(PLAN[k].data, PLAN[k].has, PLAN[k].last, PLAN[k].typed, PLAN[k].want);

        // One opening bracket too many: the body is flagged, yet the bytes
        // after it are still counted.
        repeat (255) send_item(CH_LBRACE, 1'b1, 1'b0);
        send_item(CH_LBRACKET, 1'b1, 1'b0);
        send_item(CH_RBRACE, 1'b1, 1'b1, 1'b1, '{ST_LIMIT, 16'd0, 16'd257});

        // Random bodies. Leading whitespace, then a value of a random kind,
        // then an optional tail that is either whitespace or garbage.
        while (random_items < RANDOM_ITEMS) begin
            if (random_items >= RANDOM_ITEMS - 100)
                calm <= 1'b1;
            body_bytes.delete();
            repeat ($urandom_range(0, 2)) body_bytes.push_back(white_byte());
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: add_container(24);
                5: add_string();
                6: begin
                    // Bare scalar: the first byte must not open anything.
                    do
                        b = 8'($urandom_range(8'h21, 8'hFF));
                    while (b == CH_QUOTE || b == CH_LBRACE || b == CH_LBRACKET);
                    body_bytes.push_back(b);
                    repeat ($urandom_range(0, 4))
                        body_bytes.push_back(8'($urandom_range(8'h21, 8'hFF)));
                end
                7: begin
                    // Container cut short somewhere before its end.
                    add_container(24);
                    keep = $urandom_range(1, body_bytes.size() - 1);
                    while (body_bytes.size() > keep) void'(body_bytes.pop_back());
                end
                8: repeat ($urandom_range(1, 12))
                    body_bytes.push_back(8'($urandom_range(0, 255)));
                default: ;
            endcase
            case ($urandom_range(0, 9))
                0, 1: repeat ($urandom_range(1, 3))
                    body_bytes.push_back(8'($urandom_range(0, 255)));
                2, 3, 4, 5, 6: repeat ($urandom_range(0, 2))
                    body_bytes.push_back(white_byte());
                default: ;
            endcase

            // Now and then the body is closed by an item that carries no
            // byte; an empty body always is.
            closing_item = (body_bytes.size() == 0) || ($urandom_range(0, 3) == 0);
            foreach (body_bytes[n]) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                send_item(body_bytes[n], 1'b1, !closing_item && n == body_bytes.size() - 1);
                random_items++;
            end
            if (closing_item) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                random_items++;
            end
        end
        i_valid <= 1'b0;

        while (expected_reports.size() != 0) @(posedge i_clk);
        // Wait on so that a stray report would still be caught.
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
